/* sv/skt_pkg.sv */
`timescale 1ns / 1ps

package skt_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned TYPE_W  = 8;
    localparam int unsigned FLAGS_W = 32;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned CAP_W   = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic KIND_REGISTER = 1'b0;
    localparam logic KIND_FIND     = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [KEY_W-1:0]   primary_key;
        logic [KEY_W-1:0]   secondary_key;
        logic [TYPE_W-1:0]  entry_type;
        logic [FLAGS_W-1:0] entry_flags;
    } t_req;

    typedef struct packed {
        logic               status;
        logic               hit;
        logic [TYPE_W-1:0]  hit_type;
        logic [FLAGS_W-1:0] hit_flags;
        logic [POS_W-1:0]   position;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0]   primary_key;
        logic [KEY_W-1:0]   secondary_key;
        logic [TYPE_W-1:0]  entry_type;
        logic [FLAGS_W-1:0] entry_flags;
    } t_entry;

endpackage

/* sv/sorted_pair_key_table.sv */
`timescale 1ns / 1ps

// Sorted table of up to TABLE_DEPTH entries keyed by (primary, secondary), kept in
// one synchronous memory. A request is taken when start is high and busy is low;
// its single result appears on o_rsp with o_done high for exactly one cycle and
// cannot be held off, so it must be captured then. A register request refused as
// full answers in the next cycle without raising busy. Otherwise a binary search
// runs, each probe a memory read in the search state and then a compare. A find
// hit answers from its last compare; a find miss answers from the search state
// that follows, and an update goes on to the write state. An insert ends the
// search and then moves every later entry up by one, a memory read then a write
// per entry, before the write state. Busy drops in the same cycle that the result
// appears. No clearing pass is needed after reset.
module sorted_pair_key_table #(
    parameter int unsigned TABLE_DEPTH = skt_pkg::DEPTH_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  skt_pkg::t_req             i_req,
    input  logic                      i_cfg_we,
    input  logic [skt_pkg::CAP_W-1:0] i_cfg_data,
    output logic                      o_done,
    output skt_pkg::t_rsp             o_rsp
);
    import skt_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;

    skt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

    skt_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

/* sv/skt_mem.sv */
`timescale 1ns / 1ps

module skt_mem #(
    parameter int unsigned TABLE_DEPTH = skt_pkg::DEPTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_waddr,
    input  skt_pkg::t_entry                i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_raddr,
    output skt_pkg::t_entry                o_rdata
);
    import skt_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/skt_ctrl.sv */
`timescale 1ns / 1ps

module skt_ctrl #(
    parameter int unsigned TABLE_DEPTH = skt_pkg::DEPTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  skt_pkg::t_req                  i_req,
    input  logic                           i_cfg_we,
    input  logic [skt_pkg::CAP_W-1:0]      i_cfg_data,
    output logic                           o_mem_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_mem_waddr,
    output skt_pkg::t_entry                o_mem_wdata,
    output logic                           o_mem_re,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_mem_raddr,
    input  skt_pkg::t_entry                i_mem_rdata,
    output logic                           o_done,
    output skt_pkg::t_rsp                  o_rsp
);
    import skt_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned MW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [MW-1:0] DEPTH_M = MW'(TABLE_DEPTH);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SEARCH   = 3'd1;
    localparam logic [2:0] ST_CMP      = 3'd2;
    localparam logic [2:0] ST_SHIFT_RD = 3'd3;
    localparam logic [2:0] ST_SHIFT_WR = 3'd4;
    localparam logic [2:0] ST_WRITE    = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CAP_W-1:0] r_cap;
    t_req             r_req, n_req;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [AW-1:0]    r_mid, n_mid;
    logic [CW-1:0]    r_ptr, n_ptr;
    logic             r_hit, n_hit;
    logic             r_done, n_done;
    t_rsp             r_rsp, n_rsp;

    logic                  full;
    logic [CW:0]           mid_sum;
    logic [CW-1:0]         mid_val;
    logic [CW-1:0]         ptr_m1;
    logic [2*KEY_W-1:0]    ent_key;
    logic [2*KEY_W-1:0]    req_key;
    logic                  key_eq;
    logic                  key_lt;

    // the limit that applies is the smaller of capacity and built depth
    assign full = (MW'(r_count) >= MW'(r_cap)) || (MW'(r_count) >= DEPTH_M);

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_val = mid_sum[CW:1];
    assign ptr_m1  = r_ptr - 1'b1;

    assign ent_key = {i_mem_rdata.primary_key, i_mem_rdata.secondary_key};
    assign req_key = {r_req.primary_key, r_req.secondary_key};
    assign key_eq  = (ent_key == req_key);
    assign key_lt  = (ent_key < req_key);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_req   = r_req;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_ptr   = r_ptr;
        n_hit   = r_hit;
        n_done  = 1'b0;
        n_rsp   = r_rsp;

        o_mem_we    = 1'b0;
        o_mem_waddr = r_lo[AW-1:0];
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = mid_val[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    if (i_req.kind == KIND_REGISTER && full) begin
                        n_done          = 1'b1;
                        n_rsp.status    = STATUS_FULL;
                        n_rsp.hit       = 1'b0;
                        n_rsp.hit_type  = '0;
                        n_rsp.hit_flags = '0;
                        n_rsp.position  = '0;
                    end else begin
                        n_lo    = '0;
                        n_hi    = r_count;
                        n_hit   = 1'b0;
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (r_lo < r_hi) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = mid_val[AW-1:0];
                    n_mid       = mid_val[AW-1:0];
                    n_state     = ST_CMP;
                end else if (r_req.kind == KIND_FIND) begin
                    n_done          = 1'b1;
                    n_rsp.status    = STATUS_DONE;
                    n_rsp.hit       = 1'b0;
                    n_rsp.hit_type  = '0;
                    n_rsp.hit_flags = '0;
                    n_rsp.position  = POS_W'(r_lo);
                    n_state         = ST_IDLE;
                end else begin
                    // open a gap at the insertion point, top entry first
                    n_ptr   = r_count;
                    n_state = (r_count > r_lo) ? ST_SHIFT_RD : ST_WRITE;
                end
            end
            ST_CMP: begin
                if (key_eq) begin
                    n_hit = 1'b1;
                    n_lo  = CW'(r_mid);
                    if (r_req.kind == KIND_FIND) begin
                        n_done          = 1'b1;
                        n_rsp.status    = STATUS_DONE;
                        n_rsp.hit       = 1'b1;
                        n_rsp.hit_type  = i_mem_rdata.entry_type;
                        n_rsp.hit_flags = i_mem_rdata.entry_flags;
                        n_rsp.position  = POS_W'(r_mid);
                        n_state         = ST_IDLE;
                    end else begin
                        n_state = ST_WRITE;
                    end
                end else begin
                    if (key_lt) begin
                        n_lo = CW'(r_mid) + 1'b1;
                    end else begin
                        n_hi = CW'(r_mid);
                    end
                    n_state = ST_SEARCH;
                end
            end
            ST_SHIFT_RD: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = ptr_m1[AW-1:0];
                n_state     = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr[AW-1:0];
                o_mem_wdata = i_mem_rdata;
                n_ptr       = ptr_m1;
                n_state     = (ptr_m1 > r_lo) ? ST_SHIFT_RD : ST_WRITE;
            end
            ST_WRITE: begin
                o_mem_we                  = 1'b1;
                o_mem_waddr               = r_lo[AW-1:0];
                o_mem_wdata.primary_key   = r_req.primary_key;
                o_mem_wdata.secondary_key = r_req.secondary_key;
                o_mem_wdata.entry_type    = r_req.entry_type;
                o_mem_wdata.entry_flags   = r_req.entry_flags;
                if (!r_hit) begin
                    n_count = r_count + 1'b1;
                end
                n_done          = 1'b1;
                n_rsp.status    = STATUS_DONE;
                n_rsp.hit       = r_hit;
                n_rsp.hit_type  = '0;
                n_rsp.hit_flags = '0;
                n_rsp.position  = POS_W'(r_lo);
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_ptr <= n_ptr;
        r_hit <= n_hit;
        r_rsp <= n_rsp;
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

/* sv/skt_checker.sv */
`timescale 1ns / 1ps

module skt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          i_done,
    input skt_pkg::t_rsp i_rsp
);
    import skt_pkg::*;

    // a refused register reports nothing else
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_done && i_rsp.status == STATUS_FULL) |->
            (!i_rsp.hit && i_rsp.position == '0 && i_rsp.hit_type == '0
             && i_rsp.hit_flags == '0))
        else $error("full result carries data");

    // type or flags only come back from a successful find
    a_data_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_done && (i_rsp.hit_type != '0 || i_rsp.hit_flags != '0)) |->
            (i_rsp.hit && i_rsp.status == STATUS_DONE))
        else $error("entry data without a hit");

    // every finished request ends with a result
    a_busy_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> i_done)
        else $error("busy dropped without a result");

    // a result follows a taken request or ongoing work
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> ($past(start) || $past(busy)))
        else $error("result without a request");

endmodule

bind sorted_pair_key_table skt_checker u_skt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_done  (o_done),
    .i_rsp   (o_rsp)
);
